// File: rtl/core/npcs_pkg.sv
// npcs_pkg: shared widths and the command/status structs of the palette search core
// used by npcs_ctrl, npcs_dp and nearest_palette_color_search_core; no dependencies
package npcs_pkg;

    localparam int COLOR_W = 8;
    localparam int IDX_W   = 8;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic start;
        logic issue;
        logic write;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic last_issue;
        logic busy;
    } dp_sts_t;

endpackage

// File: rtl/core/npcs_ctrl.sv
// npcs_ctrl: state machine of the palette search core, handshakes and datapath commands
// depends on npcs_pkg
module npcs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output npcs_pkg::dp_cmd_t  dp_cmd,
    input  npcs_pkg::dp_sts_t  dp_sts
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_fire;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        dp_cmd.start    = 1'b0;
        dp_cmd.issue    = 1'b0;
        dp_cmd.write    = 1'b0;
        dp_cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (cmd == npcs_pkg::CMD_QUERY)
                    begin
                        dp_cmd.start = 1'b1;
                        state_next   = ST_SCAN;
                    end
                    else
                    begin
                        dp_cmd.write = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                dp_cmd.issue = 1'b1;
                if (dp_sts.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!dp_sts.busy && out_free)
                begin
                    dp_cmd.load_out = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (dp_cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/npcs_dp.sv
// npcs_dp: palette memory with per-entry valid bits, distance pipeline and best tracker
// depends on npcs_pkg; driven by npcs_ctrl
module npcs_dp #(
    parameter int PALETTE_SIZE = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  npcs_pkg::dp_cmd_t                   dp_cmd,
    output npcs_pkg::dp_sts_t                   dp_sts,
    input  logic [npcs_pkg::IDX_W-1:0]          entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]        red,
    input  logic [npcs_pkg::COLOR_W-1:0]        green,
    input  logic [npcs_pkg::COLOR_W-1:0]        blue,
    output logic [npcs_pkg::IDX_W-1:0]          nearest_index,
    output logic [npcs_pkg::DIST_W-1:0]         nearest_distance
);

    localparam int AW  = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int CW  = npcs_pkg::COLOR_W;
    localparam int EW  = 3 * CW;
    localparam int SQW = npcs_pkg::SQ_W;
    localparam int DW  = npcs_pkg::DIST_W;
    localparam int IW  = npcs_pkg::IDX_W;

    logic [EW-1:0]  mem_reg [PALETTE_SIZE];
    logic           vld_reg [PALETTE_SIZE];

    logic [AW-1:0]  addr_reg;
    logic [AW-1:0]  addr_next;
    logic [CW-1:0]  q_r_reg;
    logic [CW-1:0]  q_g_reg;
    logic [CW-1:0]  q_b_reg;

    logic           s1_vld_reg;
    logic [AW-1:0]  s1_idx_reg;
    logic [EW-1:0]  rd_data_reg;
    logic           rd_ok_reg;

    logic           s2_vld_reg;
    logic [AW-1:0]  s2_idx_reg;
    logic [SQW-1:0] sq_r_reg;
    logic [SQW-1:0] sq_g_reg;
    logic [SQW-1:0] sq_b_reg;

    logic [DW-1:0]  best_d_reg;
    logic [DW-1:0]  best_d_next;
    logic [AW-1:0]  best_i_reg;
    logic [AW-1:0]  best_i_next;

    logic [IW-1:0]  out_idx_reg;
    logic [DW-1:0]  out_dist_reg;

    logic           wr_ok;
    logic [EW-1:0]  ent;
    logic [CW-1:0]  e_r;
    logic [CW-1:0]  e_g;
    logic [CW-1:0]  e_b;
    logic [CW-1:0]  d_r;
    logic [CW-1:0]  d_g;
    logic [CW-1:0]  d_b;
    logic [DW-1:0]  sum_dist;

    assign wr_ok = ({1'b0, entry_index} < (IW + 1)'(PALETTE_SIZE));

    // palette store, write port
    always_ff @(posedge clk)
    begin
        if (dp_cmd.write && wr_ok)
        begin
            mem_reg[entry_index[AW-1:0]] <= {red, green, blue};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PALETTE_SIZE; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (dp_cmd.write && wr_ok)
        begin
            vld_reg[entry_index[AW-1:0]] <= 1'b1;
        end
    end

    // scan address
    always_comb
    begin
        addr_next = addr_reg;
        if (dp_cmd.start)
        begin
            addr_next = '0;
        end
        else if (dp_cmd.issue)
        begin
            addr_next = addr_reg + AW'(1);
        end
    end

    assign dp_sts.last_issue = dp_cmd.issue && (addr_reg == AW'(PALETTE_SIZE - 1));
    assign dp_sts.busy       = s1_vld_reg || s2_vld_reg;

    // stage 1: registered memory read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[addr_reg];
        rd_ok_reg   <= vld_reg[addr_reg];
        s1_idx_reg  <= addr_reg;
        s2_idx_reg  <= s1_idx_reg;
        if (dp_cmd.start)
        begin
            q_r_reg <= red;
            q_g_reg <= green;
            q_b_reg <= blue;
        end
    end

    // unwritten entries read as black
    assign ent = rd_ok_reg ? rd_data_reg : '0;
    assign e_r = ent[EW-1:2*CW];
    assign e_g = ent[2*CW-1:CW];
    assign e_b = ent[CW-1:0];
    assign d_r = (e_r > q_r_reg) ? (e_r - q_r_reg) : (q_r_reg - e_r);
    assign d_g = (e_g > q_g_reg) ? (e_g - q_g_reg) : (q_g_reg - e_g);
    assign d_b = (e_b > q_b_reg) ? (e_b - q_b_reg) : (q_b_reg - e_b);

    // stage 2: squares
    always_ff @(posedge clk)
    begin
        sq_r_reg <= SQW'(d_r) * SQW'(d_r);
        sq_g_reg <= SQW'(d_g) * SQW'(d_g);
        sq_b_reg <= SQW'(d_b) * SQW'(d_b);
    end

    // stage 3: sum and keep the first minimum
    assign sum_dist = DW'(sq_r_reg) + DW'(sq_g_reg) + DW'(sq_b_reg);

    always_comb
    begin
        best_d_next = best_d_reg;
        best_i_next = best_i_reg;
        if (dp_cmd.start)
        begin
            best_d_next = '1;
            best_i_next = '0;
        end
        else if (s2_vld_reg && (sum_dist < best_d_reg))
        begin
            best_d_next = sum_dist;
            best_i_next = s2_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        best_d_reg <= best_d_next;
        best_i_reg <= best_i_next;
        if (dp_cmd.load_out)
        begin
            out_idx_reg  <= IW'(best_i_reg);
            out_dist_reg <= best_d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            addr_reg   <= addr_next;
            s1_vld_reg <= dp_cmd.issue;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    assign nearest_index    = out_idx_reg;
    assign nearest_distance = out_dist_reg;

endmodule

// File: rtl/core/nearest_palette_color_search_core.sv
// queries: the palette memory is scanned one read per cycle, and a new item is accepted
// only in idle, after the previous query's result has been loaded into the output register;
// a write item is taken one per cycle while no query is in progress
// reset clears every palette entry to black at once through per-entry valid bits
// top level: instantiates npcs_ctrl and npcs_dp, depends on npcs_pkg
module nearest_palette_color_search_core #(
    parameter int PALETTE_SIZE = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               cmd,
    input  logic [npcs_pkg::IDX_W-1:0]         entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]       red,
    input  logic [npcs_pkg::COLOR_W-1:0]       green,
    input  logic [npcs_pkg::COLOR_W-1:0]       blue,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [npcs_pkg::IDX_W-1:0]         nearest_index,
    output logic [npcs_pkg::DIST_W-1:0]        nearest_distance
);

    npcs_pkg::dp_cmd_t dp_cmd;
    npcs_pkg::dp_sts_t dp_sts;

    npcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd),
        .dp_sts    (dp_sts)
    );

    npcs_dp #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .dp_cmd           (dp_cmd),
        .dp_sts           (dp_sts),
        .entry_index      (entry_index),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .nearest_index    (nearest_index),
        .nearest_distance (nearest_distance)
    );

endmodule

// File: tb/sv/palette_search_checker.sv
`timescale 1ns / 100ps
// palette_search_checker: watches both channels of the palette search core, keeps its own
// palette, predicts the nearest entry for each query item and compares results in order
// depends on npcs_pkg for widths and command codes
module palette_search_checker #(
    parameter int PALETTE_SIZE = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          cmd,
    input  logic [npcs_pkg::IDX_W-1:0]    entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]  red,
    input  logic [npcs_pkg::COLOR_W-1:0]  green,
    input  logic [npcs_pkg::COLOR_W-1:0]  blue,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [npcs_pkg::IDX_W-1:0]    nearest_index,
    input  logic [npcs_pkg::DIST_W-1:0]   nearest_distance,
    output int                            mismatch_count,
    output int                            pending_count,
    output int                            write_count,
    output int                            query_count
);

    typedef struct packed {
        logic [npcs_pkg::IDX_W-1:0]  index;
        logic [npcs_pkg::DIST_W-1:0] distance;
    } match_t;

    logic [npcs_pkg::COLOR_W-1:0] pal_red   [PALETTE_SIZE];
    logic [npcs_pkg::COLOR_W-1:0] pal_green [PALETTE_SIZE];
    logic [npcs_pkg::COLOR_W-1:0] pal_blue  [PALETTE_SIZE];
    match_t                       expected_matches [$];
    match_t                       oldest_match;
    int                           result_count;
    int                           slot;

    function automatic match_t nearest_entry(input logic [npcs_pkg::COLOR_W-1:0] r,
                                             input logic [npcs_pkg::COLOR_W-1:0] g,
                                             input logic [npcs_pkg::COLOR_W-1:0] b);
        match_t      best;
        int unsigned best_dist;
        int unsigned cand_dist;
        int          dr;
        int          dg;
        int          db;
        int          i;
        best_dist  = 32'hFFFF_FFFF;
        best.index = '0;
        for (i = 0; i < PALETTE_SIZE; i++)
        begin
            dr        = int'(pal_red[i]) - int'(r);
            dg        = int'(pal_green[i]) - int'(g);
            db        = int'(pal_blue[i]) - int'(b);
            cand_dist = dr * dr + dg * dg + db * db;
            if (cand_dist < best_dist)
            begin
                best_dist  = cand_dist;
                best.index = i[npcs_pkg::IDX_W-1:0];
            end
        end
        best.distance = best_dist[npcs_pkg::DIST_W-1:0];
        return best;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (slot = 0; slot < PALETTE_SIZE; slot++)
            begin
                pal_red[slot]   = '0;
                pal_green[slot] = '0;
                pal_blue[slot]  = '0;
            end
            expected_matches.delete();
            result_count   <= 0;
            mismatch_count <= 0;
            pending_count  <= 0;
            write_count    <= 0;
            query_count    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (expected_matches.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result %0d: index %0d distance %0d",
                                 result_count, nearest_index, nearest_distance);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    oldest_match = expected_matches.pop_front();
                    if (nearest_index !== oldest_match.index
                        || nearest_distance !== oldest_match.distance)
                    begin
                        if (mismatch_count < 10)
                            $display("mismatch at result %0d: expected %0d/%0d, got %0d/%0d",
                                     result_count, oldest_match.index,
                                     oldest_match.distance,
                                     nearest_index, nearest_distance);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (cmd == npcs_pkg::CMD_WRITE)
                begin
                    write_count <= write_count + 1;
                    if (int'(entry_index) < PALETTE_SIZE)
                    begin
                        pal_red[entry_index]   = red;
                        pal_green[entry_index] = green;
                        pal_blue[entry_index]  = blue;
                    end
                end
                else
                begin
                    query_count <= query_count + 1;
                    expected_matches.push_back(nearest_entry(red, green, blue));
                end
            end
            pending_count <= expected_matches.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench: drives write and query items into nearest_palette_color_search_core with
// random idling on both channels; palette_search_checker predicts and compares results
module testbench;

    localparam int PALETTE_SIZE  = 256;
    localparam int QUERY_LATENCY = PALETTE_SIZE + 4;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int PHASE_COUNT   = 4;
    localparam int RECENT_DEPTH  = 16;
    localparam int CYCLE_LIMIT   = 1_500_000;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         in_valid    = 1'b0;
    logic                         in_ready;
    logic                         cmd         = npcs_pkg::CMD_WRITE;
    logic [npcs_pkg::IDX_W-1:0]   entry_index = '0;
    logic [npcs_pkg::COLOR_W-1:0] red         = '0;
    logic [npcs_pkg::COLOR_W-1:0] green       = '0;
    logic [npcs_pkg::COLOR_W-1:0] blue        = '0;
    logic                         out_valid;
    logic                         out_ready   = 1'b0;
    logic [npcs_pkg::IDX_W-1:0]   nearest_index;
    logic [npcs_pkg::DIST_W-1:0]  nearest_distance;

    int mismatch_count;
    int pending_count;
    int write_count;
    int query_count;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int cycle_count  = 0;
    int recent_fill  = 0;
    int recent_next  = 0;
    int failures;
    int phase;

    logic [3*npcs_pkg::COLOR_W-1:0] recent_colors [RECENT_DEPTH];

    nearest_palette_color_search_core #(
        .PALETTE_SIZE(PALETTE_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .entry_index(entry_index),
        .red(red),
        .green(green),
        .blue(blue),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .nearest_index(nearest_index),
        .nearest_distance(nearest_distance)
    );

    palette_search_checker #(
        .PALETTE_SIZE(PALETTE_SIZE)
    ) match_monitor (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .entry_index(entry_index),
        .red(red),
        .green(green),
        .blue(blue),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .nearest_index(nearest_index),
        .nearest_distance(nearest_distance),
        .mismatch_count(mismatch_count),
        .pending_count(pending_count),
        .write_count(write_count),
        .query_count(query_count)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready   <= ($urandom_range(0, 99) >= rx_stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic c, input logic [npcs_pkg::IDX_W-1:0] idx,
                             input logic [npcs_pkg::COLOR_W-1:0] r,
                             input logic [npcs_pkg::COLOR_W-1:0] g,
                             input logic [npcs_pkg::COLOR_W-1:0] b);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        entry_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        if (c == npcs_pkg::CMD_WRITE)
        begin
            recent_colors[recent_next] = {r, g, b};
            recent_next = (recent_next + 1) % RECENT_DEPTH;
            if (recent_fill < RECENT_DEPTH)
                recent_fill++;
        end
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    function automatic logic [npcs_pkg::COLOR_W-1:0] jitter(
        input logic [npcs_pkg::COLOR_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[npcs_pkg::COLOR_W-1:0];
    endfunction

    function automatic logic [3*npcs_pkg::COLOR_W-1:0] random_color();
        logic [31:0] rnd;
        rnd = $urandom;
        return rnd[3*npcs_pkg::COLOR_W-1:0];
    endfunction

    task automatic random_item();
        logic [3*npcs_pkg::COLOR_W-1:0] pick;
        logic [npcs_pkg::IDX_W-1:0]     idx;
        logic [31:0]                    rnd;
        int                             mode;
        rnd  = $urandom_range(0, 255);
        idx  = rnd[npcs_pkg::IDX_W-1:0];
        pick = random_color();
        mode = $urandom_range(0, 99);
        if (recent_fill > 0)
            if ($urandom_range(0, 3) != 0)
                pick = recent_colors[$urandom_range(0, recent_fill - 1)];
        if (mode < 55)
        begin
            if ($urandom_range(0, 2) != 0)
                pick = random_color();
            send_item(npcs_pkg::CMD_WRITE, idx, pick[23:16], pick[15:8], pick[7:0]);
        end
        else if (mode < 75)
            send_item(npcs_pkg::CMD_QUERY, idx, pick[23:16], pick[15:8], pick[7:0]);
        else if (mode < 88)
            send_item(npcs_pkg::CMD_QUERY, idx, jitter(pick[23:16]), jitter(pick[15:8]),
                      jitter(pick[7:0]));
        else
        begin
            pick = random_color();
            send_item(npcs_pkg::CMD_QUERY, idx, pick[23:16], pick[15:8], pick[7:0]);
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-black palette: full tie, exact match, largest distance; then 4 entries
        send_item(npcs_pkg::CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(npcs_pkg::CMD_QUERY, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(npcs_pkg::CMD_WRITE, 8'h00, 8'hff, 8'h00, 8'h00);
        send_item(npcs_pkg::CMD_WRITE, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(npcs_pkg::CMD_WRITE, 8'h80, 8'h00, 8'hff, 8'h00);
        send_item(npcs_pkg::CMD_WRITE, 8'h01, 8'h00, 8'h00, 8'hff);
        send_item(npcs_pkg::CMD_QUERY, 8'h00, 8'hff, 8'hff, 8'hff);
        send_item(npcs_pkg::CMD_QUERY, 8'h55, 8'h00, 8'h00, 8'h00);
        send_item(npcs_pkg::CMD_QUERY, 8'h00, 8'hf0, 8'h10, 8'h08);
        // tie at nonzero distance, then tie at exact match
        send_item(npcs_pkg::CMD_WRITE, 8'h1e, 8'h32, 8'h32, 8'h32);
        send_item(npcs_pkg::CMD_WRITE, 8'h28, 8'h34, 8'h32, 8'h32);
        send_item(npcs_pkg::CMD_QUERY, 8'haa, 8'h33, 8'h32, 8'h32);
        send_item(npcs_pkg::CMD_WRITE, 8'h0a, 8'h64, 8'h64, 8'h64);
        send_item(npcs_pkg::CMD_WRITE, 8'h14, 8'h64, 8'h64, 8'h64);
        send_item(npcs_pkg::CMD_QUERY, 8'h00, 8'h64, 8'h64, 8'h64);
        send_item(npcs_pkg::CMD_QUERY, 8'hff, 8'h00, 8'hfe, 8'h01);
        send_item(npcs_pkg::CMD_WRITE, 8'hff, 8'h00, 8'h00, 8'h00);
        send_item(npcs_pkg::CMD_QUERY, 8'h00, 8'hff, 8'hff, 8'hff);
        send_item(npcs_pkg::CMD_WRITE, 8'h7f, 8'haa, 8'h55, 8'haa);
        send_item(npcs_pkg::CMD_QUERY, 8'h5a, 8'haa, 8'h55, 8'haa);
        drain_results();

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 62; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
                default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
            endcase
            repeat (RANDOM_ITEMS / PHASE_COUNT)
                random_item();
            drain_results();
        end

        rx_stall_pct = 0;
        repeat (QUERY_LATENCY)
            @(posedge clk);

        failures = mismatch_count + pending_count;
        $display("run covered %0d palette writes and %0d nearest-color queries in %0d cycles",
                 write_count, query_count, cycle_count);
        $display("idling phases: none, sender 62%%, receiver 62%%, both 27%%; %0d failures",
                 failures);
        if (failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/npcs_pkg.sv
rtl/core/npcs_ctrl.sv
rtl/core/npcs_dp.sv
rtl/core/nearest_palette_color_search_core.sv
tb/sv/palette_search_checker.sv
tb/sv/testbench.sv
